// ===== rtl/k26cc_pkg.sv =====
// Shared types, widths and codes for the K2,6 completion checker.
package k26cc_pkg;

   // Fixed field widths
   localparam int ROW_W     = 5;
   localparam int COL_W     = 5;
   localparam int CFG_W     = 6;
   localparam int CSR_IDX_W = 2;

   // Default matrix size
   localparam int DEF_MAX_ROWS = 32;
   localparam int DEF_MAX_COLS = 32;

   // Register reset values
   localparam logic [CFG_W-1:0] RST_ROWS_IN_USE = 6'd32;
   localparam logic [CFG_W-1:0] RST_COLS_IN_USE = 6'd32;

   // Shared neighbors needed for a hit
   localparam int NEED_COMMON = 5;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_IN_USE = 2'd0,
      CSR_COLS_IN_USE = 2'd1
   } csr_idx_type;

   // Request kinds
   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_ROW,
      ST_WRITE,
      ST_LOAD,
      ST_WALK,
      ST_RESP
   } state_type;

endpackage

// ===== rtl/k26cc_req_if.sv =====
// Request channel: matrix writes and completion queries.
interface k26cc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [k26cc_pkg::ROW_W-1:0]  row_index;
   logic [k26cc_pkg::COL_W-1:0]  col_index;
   logic                         edge_bit;

   modport source (output valid, req_type, row_index, col_index, edge_bit, input ready);
   modport sink   (input valid, req_type, row_index, col_index, edge_bit, output ready);
endinterface

// ===== rtl/k26cc_rsp_if.sv =====
// Response channel: one query answer per word.
interface k26cc_rsp_if;
   logic valid;
   logic ready;
   logic completes_k26;

   modport source (output valid, completes_k26, input ready);
   modport sink   (input valid, completes_k26, output ready);
endinterface

// ===== rtl/k26cc_csr_if.sv =====
// Configuration write channel.
interface k26cc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [k26cc_pkg::CSR_IDX_W-1:0]  index;
   logic [k26cc_pkg::CFG_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/k26cc_row_mem.sv =====
// Adjacency row memory: one read port with registered data, one write port, row valid bits.
module k26cc_row_mem #(
   parameter int ROWS = k26cc_pkg::DEF_MAX_ROWS,
   parameter int COLS = k26cc_pkg::DEF_MAX_COLS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [$clog2(ROWS)-1:0]   rd_addr,
   output logic [COLS-1:0]           rd_row,
   input  logic                      wr_en,
   input  logic [$clog2(ROWS)-1:0]   wr_addr,
   input  logic [COLS-1:0]           wr_data
);

   logic [COLS-1:0] mem [ROWS];
   logic [COLS-1:0] rd_data_ff;
   logic            rd_vld_ff;
   logic [ROWS-1:0] vld_ff;

   // Storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Row valid bits: a row never written reads as all zeros
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_row = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/k26_completion_check.sv =====
// Top level of the K2,6 completion checker.
// The block holds a MAX_ROWS x MAX_COLS adjacency bit matrix, all zero after reset, in a
// single-read-port row memory. A write word sets or clears one bit and gives no response;
// it is accepted, then row u is read, then the row is written back. A query word for row u
// and column v reads row u, then walks rows 0 .. min(rows_in_use, MAX_ROWS)-1 one per
// cycle, ANDing each with row u masked to cols_in_use and counting the shared columns; it
// stops at the first row that has bit v set and at least five shared columns, then holds
// the response until rsp ready. A query with no row in use answers 0 without a walk. The
// rate is set by the single memory read port feeding the AND/popcount unit. Rows or columns
// beyond the matrix are ignored on writes and answer 0 on queries. Configuration must be
// written only while idle; the block itself does not enforce this.
module k26_completion_check #(
   parameter int MAX_ROWS = k26cc_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = k26cc_pkg::DEF_MAX_COLS
) (
   input  logic            clock,
   input  logic            reset,
   k26cc_req_if.sink       req_bus,
   k26cc_rsp_if.source     rsp_bus,
   k26cc_csr_if.sink       csr_bus
);

   localparam int ROW_AW = $clog2(MAX_ROWS);
   localparam int RCW    = $clog2(MAX_ROWS + 1);
   localparam int COL_AW = $clog2(MAX_COLS);
   localparam int PCW    = $clog2(MAX_COLS + 1);

   k26cc_pkg::state_type               state_ff, state_in;
   logic                               query_ff, query_in;
   logic [k26cc_pkg::ROW_W-1:0]        u_ff, u_in;
   logic [k26cc_pkg::COL_W-1:0]        v_ff, v_in;
   logic                               bit_ff, bit_in;
   logic [k26cc_pkg::CFG_W-1:0]        rows_ff, rows_in;
   logic [k26cc_pkg::CFG_W-1:0]        cols_ff, cols_in;
   logic [MAX_COLS-1:0]                urow_ff, urow_in;
   logic [RCW-1:0]                     cnt_ff, cnt_in;
   logic                               ans_ff, ans_in;

   logic                               req_acc;
   logic                               req_in_range;
   logic [RCW-1:0]                     nrows;
   logic [MAX_COLS-1:0]                col_mask;
   logic [MAX_COLS-1:0]                common_bits;
   logic [PCW-1:0]                     common_cnt;
   logic                               row_hit;

   logic                               mem_rd_en;
   logic [ROW_AW-1:0]                  mem_rd_addr;
   logic [MAX_COLS-1:0]                mem_rd_row;
   logic                               mem_wr_en;
   logic [MAX_COLS-1:0]                mem_wr_data;

   // Row memory
   k26cc_row_mem #(
      .ROWS (MAX_ROWS),
      .COLS (MAX_COLS)
   ) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_row  (mem_rd_row),
      .wr_en   (mem_wr_en),
      .wr_addr (ROW_AW'(u_ff)),
      .wr_data (mem_wr_data)
   );

   // Configuration registers; the port is always ready
   assign csr_bus.ready = 1'b1;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_bus.valid) begin
         if (csr_bus.index == k26cc_pkg::CSR_ROWS_IN_USE) begin
            rows_in = csr_bus.data;
         end
         if (csr_bus.index == k26cc_pkg::CSR_COLS_IN_USE) begin
            cols_in = csr_bus.data;
         end
      end
   end

   // Effective row count and column mask
   assign nrows = (32'(rows_ff) > 32'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_ff);

   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         col_mask[c] = (c < 32'(cols_ff));
      end
   end

   // Shared-column count of the walked row against row u
   assign common_bits = mem_rd_row & urow_ff;

   always_comb begin
      common_cnt = '0;
      for (int c = 0; c < MAX_COLS; c++) begin
         common_cnt = common_cnt + PCW'(common_bits[c]);
      end
   end

   assign row_hit = mem_rd_row[COL_AW'(v_ff)] && (common_cnt >= PCW'(k26cc_pkg::NEED_COMMON));

   // Request handshake
   assign req_acc      = req_bus.valid && req_bus.ready;
   assign req_in_range = (32'(req_bus.row_index) < 32'(MAX_ROWS)) &&
                         (32'(req_bus.col_index) < 32'(MAX_COLS));

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      query_in       = query_ff;
      u_in           = u_ff;
      v_in           = v_ff;
      bit_in         = bit_ff;
      urow_in        = urow_ff;
      cnt_in         = cnt_ff;
      ans_in         = ans_ff;
      req_bus.ready  = 1'b0;
      rsp_bus.valid  = 1'b0;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = ROW_AW'(u_ff);
      mem_wr_en      = 1'b0;
      mem_wr_data    = mem_rd_row;
      mem_wr_data[COL_AW'(v_ff)] = bit_ff;

      unique case (state_ff)
         k26cc_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_acc) begin
               query_in = (req_bus.req_type == k26cc_pkg::REQ_QUERY);
               u_in     = req_bus.row_index;
               v_in     = req_bus.col_index;
               bit_in   = req_bus.edge_bit;
               if (req_bus.req_type == k26cc_pkg::REQ_QUERY) begin
                  if (!req_in_range || (nrows == '0)) begin
                     ans_in   = 1'b0;
                     state_in = k26cc_pkg::ST_RESP;
                  end else begin
                     state_in = k26cc_pkg::ST_RD_ROW;
                  end
               end else if (req_in_range) begin
                  state_in = k26cc_pkg::ST_RD_ROW;
               end
            end
         end
         k26cc_pkg::ST_RD_ROW: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ROW_AW'(u_ff);
            state_in    = query_ff ? k26cc_pkg::ST_LOAD : k26cc_pkg::ST_WRITE;
         end
         k26cc_pkg::ST_WRITE: begin
            // read-modify-write of row u
            mem_wr_en = 1'b1;
            state_in  = k26cc_pkg::ST_IDLE;
         end
         k26cc_pkg::ST_LOAD: begin
            urow_in     = mem_rd_row & col_mask;
            cnt_in      = '0;
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            state_in    = k26cc_pkg::ST_WALK;
         end
         k26cc_pkg::ST_WALK: begin
            // row cnt_ff is on the read data; fetch the next one
            mem_rd_en   = 1'b1;
            mem_rd_addr = ROW_AW'(cnt_ff + RCW'(1));
            if (row_hit) begin
               ans_in   = 1'b1;
               state_in = k26cc_pkg::ST_RESP;
            end else if (cnt_ff == nrows - RCW'(1)) begin
               ans_in   = 1'b0;
               state_in = k26cc_pkg::ST_RESP;
            end else begin
               cnt_in = cnt_ff + RCW'(1);
            end
         end
         k26cc_pkg::ST_RESP: begin
            rsp_bus.valid = 1'b1;
            if (rsp_bus.ready) begin
               state_in = k26cc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = k26cc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_bus.completes_k26 = ans_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= k26cc_pkg::ST_IDLE;
         rows_ff  <= k26cc_pkg::RST_ROWS_IN_USE;
         cols_ff  <= k26cc_pkg::RST_COLS_IN_USE;
         cnt_ff   <= '0;
         ans_ff   <= 1'b0;
         query_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         cnt_ff   <= cnt_in;
         ans_ff   <= ans_in;
         query_ff <= query_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      u_ff    <= u_in;
      v_ff    <= v_in;
      bit_ff  <= bit_in;
      urow_ff <= urow_in;
   end

endmodule
